>>> sv/knn2d_pkg.sv
// ----------------------------------------------------------------------------
// knn2d_pkg
// Shared types and constants of the 2D k-nearest-neighbor search block.
// ----------------------------------------------------------------------------
package knn2d_pkg;

  // Width of the configuration register index.
  localparam int CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_QUERY_X         = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUERY_Y         = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_NEIGHBOUR_COUNT = 2'd2;

  // Width and reset value of the neighbor count register.
  localparam int                 CountW     = 4;
  localparam logic [CountW-1:0]  COUNT_RST  = 4'd3;

  // Command that the controller broadcasts to every cell of the list.
  typedef struct packed {
    logic ins;    // insert the candidate that leaves the distance pipeline
    logic shift;  // move every entry one place toward the head
    logic clr;    // empty the whole list
  } cell_ctl_t;

endpackage

>>> sv/knn2d_dist.sv
// ----------------------------------------------------------------------------
// knn2d_dist
// Three-stage pipeline that computes the squared Euclidean distance of a
// candidate point to the query point and carries the point along with it.
// ----------------------------------------------------------------------------
module knn2d_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] pt_x,
  input  logic signed [COORD_BITS-1:0] pt_y,
  input  logic                         pt_last,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  output logic                         out_valid,
  output logic [2*COORD_BITS:0]        out_dist,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         out_last
);

  logic signed [COORD_BITS:0]   dx;
  logic signed [COORD_BITS:0]   dy;
  logic [COORD_BITS:0]          dx_neg;
  logic [COORD_BITS:0]          dy_neg;

  logic                         s1_valid_r, s2_valid_r, s3_valid_r;
  logic                         s1_last_r, s2_last_r, s3_last_r;
  logic [COORD_BITS-1:0]        s1_adx_r, s1_ady_r;
  logic signed [COORD_BITS-1:0] s1_x_r, s1_y_r, s2_x_r, s2_y_r, s3_x_r, s3_y_r;
  logic [2*COORD_BITS-1:0]      s2_sqx_r, s2_sqy_r;
  logic [2*COORD_BITS:0]        s3_dist_r;

  // The difference of two coordinates always has a magnitude below 2**COORD_BITS.
  assign dx     = {pt_x[COORD_BITS-1], pt_x} - {q_x[COORD_BITS-1], q_x};
  assign dy     = {pt_y[COORD_BITS-1], pt_y} - {q_y[COORD_BITS-1], q_y};
  assign dx_neg = -dx;
  assign dy_neg = -dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_adx_r  <= dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    s1_ady_r  <= dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    s1_x_r    <= pt_x;
    s1_y_r    <= pt_y;
    s1_last_r <= pt_last;

    s2_sqx_r  <= s1_adx_r * s1_adx_r;
    s2_sqy_r  <= s1_ady_r * s1_ady_r;
    s2_x_r    <= s1_x_r;
    s2_y_r    <= s1_y_r;
    s2_last_r <= s1_last_r;

    s3_dist_r <= {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};
    s3_x_r    <= s2_x_r;
    s3_y_r    <= s2_y_r;
    s3_last_r <= s2_last_r;
  end

  assign out_valid = s3_valid_r;
  assign out_dist  = s3_dist_r;
  assign out_x     = s3_x_r;
  assign out_y     = s3_y_r;
  assign out_last  = s3_last_r;

endmodule

>>> sv/knn2d_cell.sv
// ----------------------------------------------------------------------------
// knn2d_cell
// One slot of the sorted neighbor list. It decides on its own whether a new
// candidate goes before its entry, and takes the new candidate, the entry of
// its nearer neighbor or the entry of its farther neighbor as commanded.
// ----------------------------------------------------------------------------
module knn2d_cell #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  knn2d_pkg::cell_ctl_t         ctl,
  input  logic [2*COORD_BITS:0]        new_dist,
  input  logic signed [COORD_BITS-1:0] new_x,
  input  logic signed [COORD_BITS-1:0] new_y,
  input  logic                         prev_before,
  input  logic                         prev_valid,
  input  logic [2*COORD_BITS:0]        prev_dist,
  input  logic signed [COORD_BITS-1:0] prev_x,
  input  logic signed [COORD_BITS-1:0] prev_y,
  input  logic                         next_valid,
  input  logic [2*COORD_BITS:0]        next_dist,
  input  logic signed [COORD_BITS-1:0] next_x,
  input  logic signed [COORD_BITS-1:0] next_y,
  output logic                         ahead,
  output logic                         valid,
  output logic [2*COORD_BITS:0]        cur_dist,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y
);

  logic                         valid_r, valid_nxt;
  logic [2*COORD_BITS:0]        dist_r, dist_nxt;
  logic signed [COORD_BITS-1:0] x_r, x_nxt;
  logic signed [COORD_BITS-1:0] y_r, y_nxt;

  // Strictly nearer only, so an equal distance keeps the earlier point ahead.
  assign ahead = !valid_r || (new_dist < dist_r);

  always_comb begin
    valid_nxt = valid_r;
    dist_nxt  = dist_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    priority if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins && prev_before) begin
      valid_nxt = prev_valid;
      dist_nxt  = prev_dist;
      x_nxt     = prev_x;
      y_nxt     = prev_y;
    end else if (ctl.ins && ahead) begin
      valid_nxt = 1'b1;
      dist_nxt  = new_dist;
      x_nxt     = new_x;
      y_nxt     = new_y;
    end else if (ctl.shift) begin
      valid_nxt = next_valid;
      dist_nxt  = next_dist;
      x_nxt     = next_x;
      y_nxt     = next_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
  end

  assign valid    = valid_r;
  assign cur_dist = dist_r;
  assign x        = x_r;
  assign y        = y_r;

endmodule

>>> sv/k_nearest_neighbour_2d.sv
// ----------------------------------------------------------------------------
// k_nearest_neighbour_2d
// Streaming brute-force k-nearest-neighbor search over 2D integer points.
// ----------------------------------------------------------------------------
// Points are taken one word per cycle while in_tready is high. Each point
// passes a three-stage squared-distance pipeline and is then inserted into a
// row of MAX_K cells that keep the nearest points sorted, earlier points first
// on equal distance. The word marked with tlast closes the batch: input stalls
// while that point runs through the pipeline and is inserted, then k result
// words (neighbour_count, saturated to MAX_K) leave nearest first, one per
// cycle while out_tready is high, the list shifting toward the head as each is
// taken. Empty slots come out with tuser low and zero coordinates. The list is
// emptied with the final result word, or on entry to readout when k is zero,
// and input opens again in the next cycle.
// Configuration is meant to be written between batches.
// ----------------------------------------------------------------------------
module k_nearest_neighbour_2d #(
  parameter int MAX_K      = 8,
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input words.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // point_x, point_y; zero pad up to whole bytes.
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                  in_tlast,    // point_last
  // Result words.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // neighbour_x, neighbour_y; zero pad up to whole bytes.
  output logic [((2*COORD_BITS+7)/8)*8-1:0]     out_tdata,
  output logic                                  out_tuser,   // neighbour_valid
  output logic                                  out_tlast,   // result_last
  // Configuration writes.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [knn2d_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data
);

  localparam int DistW = 2*COORD_BITS+1;
  localparam int KW    = $clog2(MAX_K+1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]                         state_r, state_nxt;
  logic [KW-1:0]                      k_r, k_nxt;
  logic [KW-1:0]                      remain_r, remain_nxt;
  logic signed [COORD_BITS-1:0]       qx_r, qy_r;
  logic [knn2d_pkg::CountW-1:0]       count_r;

  logic                               in_acc;
  logic                               out_acc;
  logic                               done;
  logic [KW-1:0]                      k_sat;

  logic                               d_valid;
  logic [DistW-1:0]                   d_dist;
  logic signed [COORD_BITS-1:0]       d_x, d_y;
  logic                               d_last;

  knn2d_pkg::cell_ctl_t               ctl;

  logic [MAX_K-1:0]                   c_before;
  logic [MAX_K-1:0]                   c_valid;
  logic [DistW-1:0]                   c_dist [MAX_K];
  logic signed [COORD_BITS-1:0]       c_x    [MAX_K];
  logic signed [COORD_BITS-1:0]       c_y    [MAX_K];

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r    <= '0;
      qy_r    <= '0;
      count_r <= knn2d_pkg::COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        knn2d_pkg::CFG_QUERY_X:         qx_r    <= cfg_data;
        knn2d_pkg::CFG_QUERY_Y:         qy_r    <= cfg_data;
        knn2d_pkg::CFG_NEIGHBOUR_COUNT: count_r <= cfg_data[knn2d_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  knn2d_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_acc),
    .pt_x      (in_tdata[COORD_BITS-1:0]),
    .pt_y      (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pt_last   (in_tlast),
    .q_x       (qx_r),
    .q_y       (qy_r),
    .out_valid (d_valid),
    .out_dist  (d_dist),
    .out_x     (d_x),
    .out_y     (d_y),
    .out_last  (d_last)
  );

  // Neighbor count above the list depth reads as the depth.
  assign k_sat = (32'(count_r) > 32'(MAX_K)) ? KW'(MAX_K) : KW'(count_r);

  assign out_tvalid = (state_r == ST_READ) && (remain_r != '0);
  assign out_acc    = out_tvalid && out_tready;
  assign done       = (state_r == ST_READ) &&
                      ((remain_r == '0) || (out_acc && remain_r == KW'(1)));

  assign ctl = '{ins: d_valid, shift: out_acc, clr: done};

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    remain_nxt = remain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tlast) begin
          state_nxt = ST_DRAIN;
          k_nxt     = k_sat;
        end
      end
      ST_DRAIN: begin
        if (d_valid && d_last) begin
          state_nxt  = ST_READ;
          remain_nxt = k_r;
        end
      end
      ST_READ: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
        if (out_acc) begin
          remain_nxt = remain_r - KW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      remain_r <= remain_nxt;
    end
  end

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic                         p_before, p_valid, n_valid;
    logic [DistW-1:0]             p_dist, n_dist;
    logic signed [COORD_BITS-1:0] p_x, p_y, n_x, n_y;

    if (i == 0) begin : g_head
      assign p_before = 1'b0;
      assign p_valid  = 1'b0;
      assign p_dist   = '0;
      assign p_x      = '0;
      assign p_y      = '0;
    end else begin : g_body
      assign p_before = c_before[i-1];
      assign p_valid  = c_valid[i-1];
      assign p_dist   = c_dist[i-1];
      assign p_x      = c_x[i-1];
      assign p_y      = c_y[i-1];
    end

    if (i == MAX_K-1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_dist  = '0;
      assign n_x     = '0;
      assign n_y     = '0;
    end else begin : g_inner
      assign n_valid = c_valid[i+1];
      assign n_dist  = c_dist[i+1];
      assign n_x     = c_x[i+1];
      assign n_y     = c_y[i+1];
    end

    knn2d_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_dist    (d_dist),
      .new_x       (d_x),
      .new_y       (d_y),
      .prev_before (p_before),
      .prev_valid  (p_valid),
      .prev_dist   (p_dist),
      .prev_x      (p_x),
      .prev_y      (p_y),
      .next_valid  (n_valid),
      .next_dist   (n_dist),
      .next_x      (n_x),
      .next_y      (n_y),
      .ahead       (c_before[i]),
      .valid       (c_valid[i]),
      .cur_dist    (c_dist[i]),
      .x           (c_x[i]),
      .y           (c_y[i])
    );
  end

  // The head cell is the output register; empty slots read as zero.
  always_comb begin
    out_tdata = '0;
    if (c_valid[0]) begin
      out_tdata[COORD_BITS-1:0]            = c_x[0];
      out_tdata[2*COORD_BITS-1:COORD_BITS] = c_y[0];
    end
  end
  assign out_tuser = c_valid[0];
  assign out_tlast = (remain_r == KW'(1));

  // Occupied slots always form a run from the head of the list.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((c_valid >> 1) & ~c_valid) == '0)
    else $error("neighbor list has a hole");

  a_no_input_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input open while results are pending");

  a_last_point_starts_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (d_valid && d_last) |=> (state_r == ST_READ))
    else $error("readout did not follow the last point");

  a_list_empty_after_batch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (in_tready && c_valid == '0))
    else $error("list not cleared after the final result");

  a_no_insert_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !d_valid)
    else $error("insert during readout");

endmodule
